// ===== src/mur_absorbing_boundary_update_unit_defines.svh =====
// Assertion macros for the Mur boundary update unit.
// Used by mur_absorbing_boundary_update_unit.sv; expects clk_i and rst_ni in scope.
`ifndef MUR_ABSORBING_BOUNDARY_UPDATE_UNIT_DEFINES_SVH
`define MUR_ABSORBING_BOUNDARY_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MUR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mur assertion failed");

// Next-cycle implication, checked outside reset.
`define MUR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mur assertion failed");

`endif

// ===== src/mur_pkg.sv =====
// Shared types, constants and step functions of the Mur boundary update unit.
// No dependencies.
`default_nettype none

package mur_pkg;

  localparam int unsigned LineLen    = 1024;
  localparam int unsigned PosW       = 10;
  localparam int unsigned NumComp    = 6;
  localparam int unsigned NumSides   = 4;
  localparam int unsigned StoreDepth = NumSides * NumComp * LineLen;
  localparam int unsigned AddrW      = 15;
  localparam int unsigned KFrac      = 30;
  localparam int unsigned SqSteps    = 20;
  localparam int unsigned DivSteps   = 31;
  localparam int unsigned DenW       = 53;
  localparam int unsigned RemW       = 54;
  localparam int unsigned QW         = 31;
  // stage indices of the valid pipe
  localparam int unsigned StA        = 0;
  localparam int unsigned StP        = StA + SqSteps + 1;
  localparam int unsigned StN        = StP + 1;
  localparam int unsigned StM1       = StN + DivSteps + 1;
  localparam int unsigned StM2       = StM1 + 1;
  localparam int unsigned StOut      = StM2 + 1;
  localparam int unsigned NumStages  = StOut + 1;

  typedef enum logic {
    CMD_SAVE   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    COMP_EX = 3'd0,
    COMP_EY = 3'd1,
    COMP_EZ = 3'd2,
    COMP_HX = 3'd3,
    COMP_HY = 3'd4,
    COMP_HZ = 3'd5
  } comp_e;

  typedef enum logic [1:0] {
    REG_SIDE_ENABLE = 2'd0,
    REG_LIGHT_STEP  = 2'd1,
    REG_SPACING_X   = 2'd2,
    REG_SPACING_Y   = 2'd3
  } reg_e;

  typedef struct packed {
    logic               apply;
    logic               diff_neg;
    logic [32:0]        diff_mag;
    logic signed [31:0] old_nb;
  } ctx_t;

  typedef struct packed {
    logic [39:0] rad;
    logic [21:0] rem;
    logic [19:0] root;
    logic [31:0] d;
    logic [31:0] l;
    ctx_t        ctx;
  } sq_t;

  typedef struct packed {
    logic [RemW-1:0] r;
    logic [QW-1:0]   q;
    logic [DenW-1:0] den;
    logic            neg;
    logic            zero;
    ctx_t            ctx;
  } dv_t;

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic sq_t sqrt_step(sq_t s);
    sq_t         o;
    logic [23:0] t;
    logic [23:0] trial;
    o     = s;
    t     = {s.rem, s.rad[39:38]};
    trial = {2'b00, s.root, 2'b01};
    if (t >= trial) begin
      o.rem  = 22'(t - trial);
      o.root = {s.root[18:0], 1'b1};
    end else begin
      o.rem  = t[21:0];
      o.root = {s.root[18:0], 1'b0};
    end
    o.rad = {s.rad[37:0], 2'b00};
    return o;
  endfunction

  // One quotient bit of restoring division; the first step does not shift.
  function automatic dv_t div_step(dv_t s, logic first);
    dv_t             o;
    logic [RemW-1:0] r;
    o = s;
    r = first ? s.r : {s.r[RemW-2:0], 1'b0};
    if (r >= {1'b0, s.den}) begin
      o.r = r - {1'b0, s.den};
      o.q = {s.q[QW-2:0], 1'b1};
    end else begin
      o.r = r;
      o.q = {s.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== src/mur_if.sv =====
// Handshake channels of the Mur boundary update unit: input cell and result.
// No dependencies.
`default_nettype none

interface mur_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  side;
  logic [9:0]  position;
  logic [2:0]  component;
  logic signed [31:0] neighbor_value;
  logic signed [31:0] boundary_value;
  logic [23:0] rel_permittivity;
  modport source (output valid, command, side, position, component, neighbor_value,
                  boundary_value, rel_permittivity, input ready);
  modport sink (input valid, command, side, position, component, neighbor_value,
                boundary_value, rel_permittivity, output ready);
endinterface

interface mur_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] new_value;
  logic        applied;
  modport source (output valid, new_value, applied, input ready);
  modport sink (input valid, new_value, applied, output ready);
endinterface

`default_nettype wire

// ===== src/mur_div_pipe.sv =====
// Pipelined restoring divider for the Mur coefficient, one quotient bit per stage.
// Depends on mur_pkg.
`default_nettype none

module mur_div_pipe import mur_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire dv_t  dv_i,
  output dv_t       dv_o
);

  dv_t st_q [DivSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(dv_i, 1'b1);
    end
  end

  for (genvar j = 1; j < DivSteps; j++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= div_step(st_q[j-1], 1'b0);
      end
    end
  end

  assign dv_o = st_q[DivSteps-1];

endmodule

`default_nettype wire

// ===== src/mur_absorbing_boundary_update_unit.sv =====
// Mur first-order absorbing boundary update unit: one edge cell per cycle.
// Accepts a new transaction every cycle the output side is not stalled; each
// transaction yields exactly one result. The pipe is built from a 20-stage
// square-root pipe for the refractive index and a 31-stage divider pipe for
// the coefficient, plus memory access, multiply and saturate stages.
// The whole pipe advances together: when the result is not taken, everything
// holds. Save and update share one 24576-entry store that is read and written
// at acceptance, so an update directly after the save of the same cell sees
// the saved values. The store is not cleared; updating a cell never saved is
// undefined. Registers (APB, byte address 4*i): side enable, light step,
// spacing x, spacing y; write them only while the unit is idle.
`default_nettype none
`include "mur_absorbing_boundary_update_unit_defines.svh"

module mur_absorbing_boundary_update_unit import mur_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mur_in_if.sink           in_if,
  mur_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // ---------------- configuration registers ----------------
  logic [3:0]  side_en_q;
  logic [31:0] light_q, spx_q, spy_q;
  reg_e        reg_idx;

  assign reg_idx = reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_en_q <= '0;
      light_q   <= 32'd65536;
      spx_q     <= 32'd131072;
      spy_q     <= 32'd131072;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SIDE_ENABLE: side_en_q <= pwdata[3:0];
        REG_LIGHT_STEP:  light_q   <= pwdata;
        REG_SPACING_X:   spx_q     <= pwdata;
        REG_SPACING_Y:   spy_q     <= pwdata;
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIDE_ENABLE: prdata = {28'd0, side_en_q};
      REG_LIGHT_STEP:  prdata = light_q;
      REG_SPACING_X:   prdata = spx_q;
      REG_SPACING_Y:   prdata = spy_q;
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // Advance the whole pipe whenever the output register is free or drained.
  logic [NumStages-1:0] vld_q;
  logic                 en;
  logic                 accept;

  assign en          = !vld_q[StOut] || out_if.ready;
  assign in_if.ready = en;
  assign accept      = in_if.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_if.valid};
    end
  end

  // ---------------- stage A: decode and store access ----------------
  comp_e           comp;
  logic            comp_ok;
  logic [4:0]      row;
  logic [AddrW-1:0] addr;
  logic            apply_d;

  assign comp    = comp_e'(in_if.component);
  assign comp_ok = in_if.component < 3'(NumComp);
  assign row     = 5'(in_if.side * 3'(NumComp / 2)) + 5'(in_if.side * 3'(NumComp / 2))
                   + 5'(in_if.component);
  assign addr    = {row, in_if.position};

  // low sides take no H update
  assign apply_d = (in_if.command == CMD_UPDATE) && comp_ok && side_en_q[in_if.side]
                   && !(!in_if.side[0] && (comp == COMP_HX || comp == COMP_HY
                                           || comp == COMP_HZ));

  logic [63:0] store_mem [StoreDepth];
  logic [63:0] rd_q;
  logic signed [31:0] a_nb_q;
  logic [23:0] a_eps_q;
  logic [31:0] a_d_q, a_l_q;
  logic        a_apply_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (in_if.command == CMD_SAVE && comp_ok) begin
        store_mem[addr] <= {in_if.boundary_value, in_if.neighbor_value};
      end
      rd_q <= store_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_nb_q    <= in_if.neighbor_value;
      a_eps_q   <= (in_if.rel_permittivity < 24'd65536) ? 24'd65536
                                                        : in_if.rel_permittivity;
      a_d_q     <= (comp == COMP_EY || comp == COMP_HY) ? spy_q : spx_q;
      a_l_q     <= light_q;
      a_apply_q <= apply_d;
    end
  end

  // ---------------- square root pipe ----------------
  sq_t         sq_in;
  logic signed [32:0] diff;

  assign diff = 33'(a_nb_q) - 33'(signed'(rd_q[63:32]));

  always_comb begin
    sq_in              = '0;
    sq_in.rad          = {a_eps_q, 16'd0};
    sq_in.d            = a_d_q;
    sq_in.l            = a_l_q;
    sq_in.ctx.apply    = a_apply_q;
    sq_in.ctx.diff_neg = diff[32];
    sq_in.ctx.diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    sq_in.ctx.old_nb   = signed'(rd_q[31:0]);
  end

  sq_t sq_q [SqSteps];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= sqrt_step(sq_in);
    end
  end

  for (genvar j = 1; j < SqSteps; j++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[j] <= sqrt_step(sq_q[j-1]);
      end
    end
  end

  // ---------------- stage P: d * n ----------------
  logic [51:0] p_dn_q;
  logic [31:0] p_l_q;
  ctx_t        p_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dn_q  <= 52'(sq_q[SqSteps-1].d) * 52'(sq_q[SqSteps-1].root);
      p_l_q   <= sq_q[SqSteps-1].l;
      p_ctx_q <= sq_q[SqSteps-1].ctx;
    end
  end

  // ---------------- stage N: numerator and denominator ----------------
  logic [DenW-1:0] lt_w, dn_w, den_w;
  dv_t             n_q;
  dv_t             dv_out;

  assign lt_w  = DenW'({p_l_q, 16'd0});
  assign dn_w  = DenW'(p_dn_q);
  assign den_w = lt_w + dn_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q.den  <= den_w;
      n_q.neg  <= dn_w > lt_w;
      n_q.r    <= RemW'((dn_w > lt_w) ? (dn_w - lt_w) : (lt_w - dn_w));
      n_q.q    <= '0;
      n_q.zero <= den_w == '0;
      n_q.ctx  <= p_ctx_q;
    end
  end

  mur_div_pipe u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .dv_i  (n_q),
    .dv_o  (dv_out)
  );

  // ---------------- stage M1: partial products ----------------
  logic [QW-1:0] kq;
  logic [48:0]   m1_lo_q;
  logic [47:0]   m1_hi_q;
  logic          m1_neg_q;
  ctx_t          m1_ctx_q;

  assign kq = dv_out.zero ? '0 : dv_out.q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_lo_q  <= 49'(dv_out.ctx.diff_mag) * 49'(kq[15:0]);
      m1_hi_q  <= 48'(dv_out.ctx.diff_mag) * 48'(kq[QW-1:16]);
      m1_neg_q <= dv_out.ctx.diff_neg ^ dv_out.neg;
      m1_ctx_q <= dv_out.ctx;
    end
  end

  // ---------------- stage M2: sum and round half away ----------------
  logic [63:0] prod;
  logic [63:0] prod_rnd;
  logic [33:0] m2_mag_q;
  logic        m2_neg_q;
  ctx_t        m2_ctx_q;

  assign prod     = 64'(m1_lo_q) + {m1_hi_q, 16'd0};
  assign prod_rnd = prod + (64'd1 << (KFrac - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_mag_q <= prod_rnd[KFrac +: 34];
      m2_neg_q <= m1_neg_q;
      m2_ctx_q <= m1_ctx_q;
    end
  end

  // ---------------- output stage: add and saturate ----------------
  logic signed [35:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] out_val_q;
  logic               out_app_q;

  assign sum = 36'(m2_ctx_q.old_nb)
               + (m2_neg_q ? -signed'(36'(m2_mag_q)) : signed'(36'(m2_mag_q)));

  always_comb begin
    priority if (sum > 36'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -36'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_val_q <= m2_ctx_q.apply ? sat : '0;
      out_app_q <= m2_ctx_q.apply;
    end
  end

  assign out_if.valid     = vld_q[StOut];
  assign out_if.new_value = out_val_q;
  assign out_if.applied   = out_app_q;

  // ---------------- assertions ----------------
  `MUR_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(vld_q))
  `MUR_ASSERT_NEXT(a_accept_enters, accept, vld_q[StA])
  `MUR_ASSERT_IMPL(a_unapplied_zero, out_if.valid && !out_if.applied, out_if.new_value == '0)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the Mur first-order absorbing boundary update unit.
// Depends on mur_pkg and the mur_in_if / mur_out_if interfaces from the RTL.
`default_nettype none

module tb import mur_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 57;
  localparam int unsigned NumRandom  = 500;

  typedef struct packed {
    logic               command;
    logic [1:0]         side;
    logic [9:0]         position;
    logic [2:0]         component;
    logic signed [31:0] neighbor_value;
    logic signed [31:0] boundary_value;
    logic [23:0]        rel_permittivity;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic               applied;
  } edge_result_t;

  // Directed row: the cell, and a typed-in result where it is obvious.
  typedef struct packed {
    cell_t        stim;
    logic         known;
    edge_result_t want;
  } row_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  mur_in_if  in_ch ();
  mur_out_if out_ch ();

  mur_absorbing_boundary_update_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch.sink),
    .out_if  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the registers and the cell stores.
  logic [3:0]  sh_side_enable;
  logic [31:0] sh_light_step, sh_spacing_x, sh_spacing_y;
  logic [31:0] sh_old_boundary [StoreDepth];
  logic [31:0] sh_old_neighbor [StoreDepth];
  bit          sh_written      [StoreDepth];

  edge_result_t pending_results[$];
  int unsigned  n_errors, n_results, n_applied, n_sent;
  longint unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Global watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  function automatic int unsigned store_index(cell_t c);
    return (int'(c.side) * NumComp + int'(c.component)) * LineLen + int'(c.position);
  endfunction

  // Bit-serial integer square root of a 40-bit radicand.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else root = root >> 1;
      bitv >>= 2;
    end
    return root;
  endfunction

  // Reflection coefficient k in Q1.30, truncated toward zero.
  function automatic longint mur_coeff(logic [23:0] eps, logic [31:0] d);
    logic [63:0] e, nq, lt, dn, den, mag, r, q;
    e   = (eps < 24'd65536) ? 64'd65536 : 64'(eps);
    nq  = int_sqrt(e << 16);
    lt  = 64'(sh_light_step) << 16;
    dn  = 64'(d) * nq;
    den = lt + dn;
    if (den == 0) return 0;
    mag = (dn > lt) ? dn - lt : lt - dn;
    q   = mag / den;
    r   = mag % den;
    for (int i = 0; i < KFrac; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return (dn > lt) ? -longint'(q) : longint'(q);
  endfunction

  // Predict the result of one cell and update the shadow stores.
  function automatic edge_result_t predict_boundary(cell_t c);
    edge_result_t res;
    int unsigned  a;
    logic [31:0]  d;
    longint       k, diff, prod, mag, term, val;
    res = '0;
    if (c.component > COMP_HZ) return res;
    a = store_index(c);
    if (c.command == CMD_SAVE) begin
      sh_old_boundary[a] = c.boundary_value;
      sh_old_neighbor[a] = c.neighbor_value;
      sh_written[a]      = 1'b1;
      return res;
    end
    if (!sh_side_enable[c.side]) return res;
    if (!c.side[0] && c.component >= COMP_HX) return res;
    d    = (c.component == COMP_EY || c.component == COMP_HY) ? sh_spacing_y : sh_spacing_x;
    k    = mur_coeff(c.rel_permittivity, d);
    diff = longint'(c.neighbor_value) - longint'($signed(sh_old_boundary[a]));
    prod = diff * k;
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + (64'sd1 <<< (KFrac - 1))) >>> KFrac;
    term = (prod < 0) ? -mag : mag;
    val  = longint'($signed(sh_old_neighbor[a])) + term;
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    res.new_value = 32'(val);
    res.applied   = 1'b1;
    return res;
  endfunction

  // Result side: random stalls, compare in order.
  initial begin
    edge_result_t want;
    int unsigned  hold;
    out_ch.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if ((n_results / 64) % 3 == 2) hold = 0;  // stretches with no back-pressure
      repeat (hold) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i iff out_ch.valid);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.new_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.new_value !== want.new_value)
          report_mismatch("new_value", out_ch.new_value, want.new_value);
        if (out_ch.applied !== want.applied)
          report_mismatch("applied", 32'(out_ch.applied), 32'(want.applied));
        n_applied += out_ch.applied;
      end
      n_results++;
    end
  end

  // One APB write: setup then access; pready is always high.
  task automatic apb_write(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i iff pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIDE_ENABLE: sh_side_enable = value[3:0];
      REG_LIGHT_STEP:  sh_light_step  = value;
      REG_SPACING_X:   sh_spacing_x   = value;
      REG_SPACING_Y:   sh_spacing_y   = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] en, input logic [31:0] lt,
                           input logic [31:0] sx, input logic [31:0] sy);
    apb_write(REG_SIDE_ENABLE, 32'(en));
    apb_write(REG_LIGHT_STEP, lt);
    apb_write(REG_SPACING_X, sx);
    apb_write(REG_SPACING_Y, sy);
  endtask

  // Drain: drop valid, wait for all expectations, then let the pipe settle.
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Send one cell after a random gap; the prediction is taken on acceptance.
  // Valid stays high afterwards until the next gap or a drain.
  task automatic send_cell(input cell_t c, input bit known, input edge_result_t want);
    edge_result_t got;
    int unsigned  gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if ((n_sent / 48) % 3 == 1) gap = 0;  // back-to-back bursts
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.command          <= c.command;
    in_ch.side             <= c.side;
    in_ch.position         <= c.position;
    in_ch.component        <= c.component;
    in_ch.neighbor_value   <= c.neighbor_value;
    in_ch.boundary_value   <= c.boundary_value;
    in_ch.rel_permittivity <= c.rel_permittivity;
    @(posedge clk_i iff in_ch.ready);
    got = predict_boundary(c);
    if (known && got.new_value !== want.new_value)
      report_mismatch("table new_value", got.new_value, want.new_value);
    if (known && got.applied !== want.applied)
      report_mismatch("table applied", 32'(got.applied), 32'(want.applied));
    pending_results.push_back(got);
    n_sent++;
  endtask

  function automatic cell_t mk_cell(cmd_e cmd, logic [1:0] sd, logic [9:0] pos,
                                    comp_e comp, logic [31:0] nb, logic [31:0] bd,
                                    logic [23:0] eps);
    cell_t c;
    c = '{cmd, sd, pos, comp, nb, bd, eps};
    return c;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] rand_eps();
    case ($urandom_range(0, 4))
      0: return 24'($urandom_range(0, 65535));  // clamped to 1.0
      1: return 24'hff_ffff;
      default: return 24'($urandom_range(65536, 16777215));
    endcase
  endfunction

  // Random cell: mostly an update of a saved cell, with saves and noise mixed in.
  task automatic random_cell(input int unsigned pos_span);
    cell_t c;
    c.side      = 2'($urandom_range(0, 3));
    c.position  = 10'($urandom_range(0, pos_span));
    c.component = 3'($urandom_range(0, 5));
    c.neighbor_value   = rand_field();
    c.boundary_value   = rand_field();
    c.rel_permittivity = rand_eps();
    if (!sh_written[store_index(c)] || $urandom_range(0, 2) == 0)
      c.command = CMD_SAVE;
    else c.command = CMD_UPDATE;
    if ($urandom_range(0, 30) == 0) c.component = 3'($urandom_range(6, 7));
    send_cell(c, 1'b0, '0);
  endtask

  row_t directed[$];

  initial begin
    edge_result_t zero_res;
    zero_res = '0;
    rst_ni = 1'b0;
    cycle_count = 0;
    n_errors = 0; n_results = 0; n_applied = 0; n_sent = 0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.command <= CMD_SAVE; in_ch.side <= '0;
    in_ch.position <= '0; in_ch.component <= COMP_EX; in_ch.neighbor_value <= '0;
    in_ch.boundary_value <= '0; in_ch.rel_permittivity <= 24'h01_0000;
    sh_side_enable = 4'h0; sh_light_step = 32'd65536;
    sh_spacing_x = 32'd131072; sh_spacing_y = 32'd131072;
    for (int i = 0; i < StoreDepth; i++) sh_written[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: after reset all sides are off, so updates return nothing applied.
    directed.push_back('{mk_cell(CMD_SAVE, 2'd0, 10'd0, COMP_EX, 32'h7fff_ffff,
                                 32'h8000_0000, 24'h01_0000), 1'b1, zero_res});
    directed.push_back('{mk_cell(CMD_UPDATE, 2'd0, 10'd0, COMP_EX, 32'h1234_5678,
                                 32'h0, 24'h01_0000), 1'b1, zero_res});
    foreach (directed[i]) send_cell(directed[i].stim, directed[i].known, directed[i].want);
    directed.delete();
    drain_pipe();

    // Enable all sides: every component on every side, extremes of the values.
    configure(4'hf, 32'd65536, 32'd131072, 32'd131072);
    for (int s = 0; s < 4; s++)
      for (int comp = 0; comp < 6; comp++) begin
        send_cell(mk_cell(CMD_SAVE, 2'(s), (s == 3) ? 10'd1023 : 10'd5, comp_e'(comp),
                          32'h8000_0000, 32'h7fff_ffff, 24'h00_0000), 1'b0, zero_res);
        // low-side H updates are typed in: nothing applied
        send_cell(mk_cell(CMD_UPDATE, 2'(s), (s == 3) ? 10'd1023 : 10'd5, comp_e'(comp),
                          32'h7fff_ffff, 32'h0, 24'hff_ffff),
                  (!s[0] && comp >= 3), zero_res);
      end
    // Component out of range: the update gives nothing applied.
    send_cell(mk_cell(CMD_UPDATE, 2'd1, 10'd5, comp_e'(3'd7), 32'h1, 32'h1,
                      24'h01_0000), 1'b1, zero_res);
    drain_pipe();

    // Random phases over several register settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(4'hf, 32'd65536, 32'd131072, 32'd65536);
        1: configure(4'h5, 32'hffff_ffff, 32'd1, 32'hffff_ffff);
        2: configure(4'ha, 32'd1, 32'hffff_ffff, 32'd1);
        3: configure(4'hf, 32'd0, 32'd0, 32'd0);
        4: configure(4'(($urandom)), $urandom, $urandom, $urandom);
        default: configure(4'hf, $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20),
                           $urandom_range(1, 1 << 20));
      endcase
      for (int i = 0; i < NumRandom / 6; i++) begin
        // Hold the sender mid-phase until every result has come back.
        if (ph == 2 && i == NumRandom / 12) drain_pipe();
        random_cell((ph == 5) ? 1023 : 7);
      end
      drain_pipe();
    end

    $display("ran %0d cells over 8 register settings, %0d results, %0d updates applied",
             n_sent, n_results, n_applied);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors", n_errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
